// ----- hdl/button_press_classifier_defines.svh -----
// Assertion macros shared by the button press classifier RTL.
// Depends on nothing; files that assert include it by name.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button press classifier check failed");

// The consequent holds in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button press classifier check failed");

`else

`define BPC_ASSERT_SAME(label, ante, cons)
`define BPC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CntW  = 16;
    localparam int AddrW = 4;
    localparam int DataW = 32;

    localparam logic [CntW-1:0] CntMax = '1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_MIN      = 2'd2;
    localparam logic [1:0] REG_BLINK    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CntW-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CntW-1:0] LONG_RST     = 16'd5000;
    localparam logic [CntW-1:0] MIN_RST      = 16'd50;
    localparam logic [CntW-1:0] BLINK_RST    = 16'd150;

    // Event codes.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_MEASURE = 2'd1;
    localparam logic [1:0] EV_UNCFG   = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    typedef struct packed {
        logic button_level;
        logic configured;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       led_write;
        logic       led_level;
        logic       fast_blink_active;
    } out_item_t;

    typedef struct packed {
        logic [CntW-1:0] debounce_ticks;
        logic [CntW-1:0] long_press_ticks;
        logic [CntW-1:0] min_press_ticks;
        logic [CntW-1:0] blink_half_period;
    } cfg_t;

    // Saturating increment of a tick counter.
    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? CntMax : v + 1'b1;
    endfunction

endpackage

// ----- hdl/button_press_classifier.sv -----
// Top level of the button press classifier: input register, core, result register.
// Depends on bpc_pkg, bpc_cfg_regs, bpc_core and the assertion macro header.
//
// Usage:
// The in channel carries one transaction per millisecond tick: the sampled
// active-low button level and the configured flag. The out channel returns
// exactly one transaction per input: event code, LED write strobe and level,
// and the fast-blink flag. Both channels use valid/ready.
// An input transaction is registered on acceptance, processed by the core and
// captured in the result register when that register is free; the result register
// then offers it on the out channel. A new transaction can be accepted every
// cycle while the receiver takes results, so sustained throughput is one tick
// per cycle, as the core updates its state for each tick it advances.
// When the receiver stalls, the result register holds its transaction, the
// input register fills, and then in_ready drops until out_ready returns.
// Reset clears the press state (button released, no hold) and loads the
// configuration defaults: debounce 50, long press 5000, minimum 50, blink 150.
// The APB port writes the four 16-bit registers at byte offsets 0, 4, 8, 12.
`timescale 1ns / 1ps
`include "button_press_classifier_defines.svh"

module button_press_classifier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bpc_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bpc_pkg::out_item_t         out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::AddrW-1:0]  paddr,
    input  logic [bpc_pkg::DataW-1:0]  pwdata,
    output logic [bpc_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import bpc_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t core_result;
    logic      out_free;
    logic      advance;
    logic      out_is_long;
    logic      out_is_short;
    logic      out_led_high;

    bpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the result register frees when empty or taken this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

    bpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_item;
        end
    end

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    // Decoded views of the offered result for the checks below.
    assign out_is_long  = out_valid && (out_item.event_res == EV_LONG);
    assign out_is_short = out_valid && ((out_item.event_res == EV_MEASURE) ||
                                        (out_item.event_res == EV_UNCFG));
    assign out_led_high = out_item.led_write && out_item.led_level;

    // A long press always ends the fast blink.
    `BPC_ASSERT_SAME(a_long_stops_blink, out_is_long, !out_item.fast_blink_active)
    // A short press is reported only on release, which drives the LED high.
    `BPC_ASSERT_SAME(a_short_on_release, out_is_short, out_led_high && !out_item.fast_blink_active)
    // The LED level is zero whenever it is not driven.
    `BPC_ASSERT_SAME(a_led_idle_low, out_valid && !out_item.led_write, !out_item.led_level)
    // Both stages full and a stalled receiver must block the input.
    `BPC_ASSERT_SAME(a_full_blocks, in_valid_reg && out_valid_reg && !out_ready, !in_ready)
    // A processed transaction always lands in the result register.
    `BPC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg)

endmodule

// ----- hdl/bpc_cfg_regs.sv -----
// APB-style configuration register file for the button press classifier.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::AddrW-1:0]  paddr,
    input  logic [bpc_pkg::DataW-1:0]  pwdata,
    output logic [bpc_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output bpc_pkg::cfg_t              cfg
);
    import bpc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write decode; only the low 16 bits of the data are kept.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DEBOUNCE: cfg_next.debounce_ticks    = pwdata[CntW-1:0];
                REG_LONG:     cfg_next.long_press_ticks  = pwdata[CntW-1:0];
                REG_MIN:      cfg_next.min_press_ticks   = pwdata[CntW-1:0];
                REG_BLINK:    cfg_next.blink_half_period = pwdata[CntW-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks  <= LONG_RST;
            cfg_reg.min_press_ticks   <= MIN_RST;
            cfg_reg.blink_half_period <= BLINK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, zero extended to the bus width.
    always_comb
    begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = {{(DataW-CntW){1'b0}}, cfg_reg.debounce_ticks};
            REG_LONG:     prdata = {{(DataW-CntW){1'b0}}, cfg_reg.long_press_ticks};
            REG_MIN:      prdata = {{(DataW-CntW){1'b0}}, cfg_reg.min_press_ticks};
            REG_BLINK:    prdata = {{(DataW-CntW){1'b0}}, cfg_reg.blink_half_period};
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/bpc_core.sv -----
// Debounce, press tracking, blink and event logic of the classifier.
// Holds the per-tick state; depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  bpc_pkg::in_item_t  item,
    input  bpc_pkg::cfg_t      cfg,
    output bpc_pkg::out_item_t result
);
    import bpc_pkg::*;

    logic            prev_level_reg,  prev_level_next;
    logic [CntW-1:0] stable_cnt_reg,  stable_cnt_next;
    logic            held_reg,        held_next;
    logic            long_done_reg,   long_done_next;
    logic [CntW-1:0] hold_cnt_reg,    hold_cnt_next;
    logic [CntW-1:0] blink_cnt_reg,   blink_cnt_next;
    logic            blink_level_reg, blink_level_next;
    logic            blink_flag_reg,  blink_flag_next;

    // One tick of the classifier, evaluated in model order.
    always_comb
    begin
        prev_level_next  = item.button_level;
        held_next        = held_reg;
        long_done_next   = long_done_reg;
        blink_level_next = blink_level_reg;
        blink_flag_next  = blink_flag_reg;
        hold_cnt_next    = held_reg ? sat_inc(hold_cnt_reg)  : hold_cnt_reg;
        blink_cnt_next   = held_reg ? sat_inc(blink_cnt_reg) : blink_cnt_reg;
        stable_cnt_next  = (item.button_level != prev_level_reg) ? '0
                                                                 : sat_inc(stable_cnt_reg);
        result.event_res = EV_NONE;
        result.led_write = 1'b0;
        result.led_level = 1'b0;

        if (stable_cnt_next > cfg.debounce_ticks)
        begin
            if (!item.button_level && !held_reg)
            begin
                // Qualified press starts a new hold.
                hold_cnt_next    = '0;
                held_next        = 1'b1;
                long_done_next   = 1'b0;
                blink_flag_next  = 1'b1;
                blink_cnt_next   = '0;
                blink_level_next = 1'b0;
            end
            else if (item.button_level && held_reg)
            begin
                // Qualified release; a short press is reported if in range.
                held_next        = 1'b0;
                blink_flag_next  = 1'b0;
                result.led_write = 1'b1;
                result.led_level = 1'b1;
                if (!long_done_reg && (hold_cnt_next > cfg.min_press_ticks) &&
                    (hold_cnt_next < cfg.long_press_ticks))
                begin
                    result.event_res = item.configured ? EV_MEASURE : EV_UNCFG;
                end
            end

            // Fast blink while held and before the long press.
            if (held_next && !long_done_next)
            begin
                if (blink_cnt_next >= cfg.blink_half_period)
                begin
                    blink_cnt_next   = '0;
                    blink_level_next = !blink_level_next;
                end
                result.led_write = 1'b1;
                result.led_level = blink_level_next;
            end

            // Long press fires once.
            if (held_next && !long_done_next && (hold_cnt_next >= cfg.long_press_ticks))
            begin
                long_done_next   = 1'b1;
                blink_flag_next  = 1'b0;
                result.event_res = EV_LONG;
            end
        end

        result.fast_blink_active = blink_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b1;
            stable_cnt_reg  <= '0;
            held_reg        <= 1'b0;
            long_done_reg   <= 1'b0;
            hold_cnt_reg    <= '0;
            blink_cnt_reg   <= '0;
            blink_level_reg <= 1'b0;
            blink_flag_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prev_level_reg  <= prev_level_next;
            stable_cnt_reg  <= stable_cnt_next;
            held_reg        <= held_next;
            long_done_reg   <= long_done_next;
            hold_cnt_reg    <= hold_cnt_next;
            blink_cnt_reg   <= blink_cnt_next;
            blink_level_reg <= blink_level_next;
            blink_flag_reg  <= blink_flag_next;
        end
    end

endmodule

// ----- bench/tb_button_press_classifier.sv -----
// Self-checking testbench for the button press classifier.
// Depends on bpc_pkg and button_press_classifier; a tick predictor checks every result.
`timescale 1ns / 1ps

module tb_button_press_classifier;

    import bpc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;
    localparam int PHASES          = 8;
    localparam int PHASE_TICKS     = 100;
    localparam int MAX_REPORTS     = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrW-1:0]    paddr = '0;
    logic [DataW-1:0]    pwdata = '0;
    logic [DataW-1:0]    prdata;
    logic                pready;

    // Ticks waiting to be sent and results predicted for accepted ticks.
    in_item_t            tick_q[$];
    out_item_t           predicted_out_q[$];

    // Configuration as written over the register port.
    cfg_t                shadow_cfg = {DEBOUNCE_RST, LONG_RST, MIN_RST, BLINK_RST};

    // Predictor state, starting from the reset values of the block.
    logic                last_level = 1'b1;
    logic [CntW-1:0]     stable_run = '0;
    logic                pressed = 1'b0;
    logic                long_fired = 1'b0;
    logic [CntW-1:0]     hold_ticks = '0;
    logic [CntW-1:0]     blink_ticks = '0;
    logic                led_phase = 1'b0;
    logic                blinking = 1'b0;

    int unsigned         send_gap = 0;
    int unsigned         burst_left = 0;
    int unsigned         stall_left = 0;
    int unsigned         ready_streak = 0;
    int unsigned         results_seen = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         fail_count = 0;

    button_press_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Tick counters stop at their all-ones value.
    function automatic logic [CntW-1:0] sat_bump(input logic [CntW-1:0] v);
        return v + (~&v);
    endfunction

    // Advances the predicted press state by one tick and returns its result.
    function automatic out_item_t classify_tick(input in_item_t tick);
        out_item_t res;
        res = '0;
        if (pressed)
        begin
            hold_ticks  = sat_bump(hold_ticks);
            blink_ticks = sat_bump(blink_ticks);
        end
        if (tick.button_level != last_level)
            stable_run = '0;
        else
            stable_run = sat_bump(stable_run);

        if (stable_run > shadow_cfg.debounce_ticks)
        begin
            if (!tick.button_level && !pressed)
            begin
                hold_ticks  = '0;
                blink_ticks = '0;
                led_phase   = 1'b0;
                pressed     = 1'b1;
                long_fired  = 1'b0;
                blinking    = 1'b1;
            end
            else if (tick.button_level && pressed)
            begin
                pressed           = 1'b0;
                blinking          = 1'b0;
                res.led_write     = 1'b1;
                res.led_level     = 1'b1;
                // A short press lies strictly between the minimum and the long time.
                if (!long_fired && hold_ticks > shadow_cfg.min_press_ticks &&
                    hold_ticks < shadow_cfg.long_press_ticks)
                    res.event_res = tick.configured ? EV_MEASURE : EV_UNCFG;
            end

            if (pressed && !long_fired)
            begin
                if (blink_ticks >= shadow_cfg.blink_half_period)
                begin
                    blink_ticks = '0;
                    led_phase   = ~led_phase;
                end
                res.led_write = 1'b1;
                res.led_level = led_phase;
            end

            if (pressed && !long_fired && hold_ticks >= shadow_cfg.long_press_ticks)
            begin
                long_fired    = 1'b1;
                blinking      = 1'b0;
                res.event_res = EV_LONG;
            end
        end
        last_level = tick.button_level;
        res.fast_blink_active = blinking;
        return res;
    endfunction

    task automatic flag_field(input string field, input int unsigned want_v,
                              input int unsigned got_v);
        if (fail_count < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
        fail_count = fail_count + 1;
    endtask

    // Driver: offers queued ticks, holding each until its transaction completes.
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned roll;
        int unsigned gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_out_q.push_back(classify_tick(in_item));

            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    // Mostly short gaps, a few long ones, and bursts without any.
                    if (burst_left > 0)
                    begin
                        burst_left = burst_left - 1;
                        gap = 0;
                    end
                    else
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 3)
                        begin
                            burst_left = $urandom_range(30, 80);
                            gap = 0;
                        end
                        else if (roll < 65)
                            gap = 0;
                        else if (roll < 95)
                            gap = $urandom_range(1, 3);
                        else
                            gap = $urandom_range(10, 40);
                    end
                    in_item  <= tick_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= gap;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and throttles out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t   want;
        int unsigned roll;
        int unsigned next_stall;
        logic        next_ready;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_stall = stall_left;
            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (predicted_out_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $error("result transaction with no tick waiting for it");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = predicted_out_q.pop_front();
                    if (out_item.event_res !== want.event_res)
                        flag_field("event_res", 32'(want.event_res),
                                   32'(out_item.event_res));
                    if (out_item.led_write !== want.led_write)
                        flag_field("led_write", 32'(want.led_write),
                                   32'(out_item.led_write));
                    if (out_item.led_level !== want.led_level)
                        flag_field("led_level", 32'(want.led_level),
                                   32'(out_item.led_level));
                    if (out_item.fast_blink_active !== want.fast_blink_active)
                        flag_field("fast_blink_active", 32'(want.fast_blink_active),
                                   32'(out_item.fast_blink_active));
                end
                // Now and then hold off long enough for the block to back up.
                if (results_seen == 300 || $urandom_range(0, 2999) == 0)
                    next_stall = HOLD_OFF_CYCLES;
            end

            if (next_stall > 0)
            begin
                next_ready = 1'b0;
                next_stall = next_stall - 1;
            end
            else if (ready_streak > 0)
            begin
                next_ready   = 1'b1;
                ready_streak = ready_streak - 1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                next_ready = 1'b1;
                if (roll < 3)
                    ready_streak = $urandom_range(40, 120);
                else if (roll >= 96)
                begin
                    next_ready = 1'b0;
                    next_stall = $urandom_range(8, 40);
                end
                else if (roll >= 70)
                begin
                    next_ready = 1'b0;
                    next_stall = $urandom_range(0, 3);
                end
            end
            out_ready  <= next_ready;
            stall_left <= next_stall;
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [CntW-1:0] value);
        logic [15:0] upper;
        upper = 16'($urandom);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE: shadow_cfg.debounce_ticks    = value;
            REG_LONG:     shadow_cfg.long_press_ticks  = value;
            REG_MIN:      shadow_cfg.min_press_ticks   = value;
            REG_BLINK:    shadow_cfg.blink_half_period = value;
            default:      ;
        endcase
    endtask

    task automatic set_config(input logic [CntW-1:0] debounce, input logic [CntW-1:0] long_t,
                              input logic [CntW-1:0] min_t, input logic [CntW-1:0] blink);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_LONG, long_t);
        write_reg(REG_MIN, min_t);
        write_reg(REG_BLINK, blink);
    endtask

    task automatic push_ticks(input logic level, input logic cfg, input int n);
        in_item_t tick;
        tick.button_level = level;
        tick.configured   = cfg;
        repeat (n) tick_q.push_back(tick);
    endtask

    // Waits until every tick is sent and answered, then lets the block settle.
    task automatic wait_drained();
        while (tick_q.size() != 0 || in_valid || predicted_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Press and release sequences with random lengths, plus glitches and cut-short presses.
    task automatic random_presses(input int target);
        int count;
        int deb;
        int span;
        int n;
        int unsigned roll;
        count = 0;
        deb   = int'(shadow_cfg.debounce_ticks);
        span  = (shadow_cfg.long_press_ticks > 16'd100) ? 100
                                                         : int'(shadow_cfg.long_press_ticks);
        while (count < target)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 2)
            begin
                n = $urandom_range(1, deb + 1);
                push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n);
                count = count + n;
            end
            else
            begin
                if (roll == 2)
                    n = $urandom_range(1, deb + 2);
                else
                    n = deb + 1 + $urandom_range(0, span + 5);
                push_ticks(1'b0, 1'($urandom_range(0, 1)), n);
                count = count + n;
                n = deb + 1 + $urandom_range(0, 4);
                push_ticks(1'b1, 1'($urandom_range(0, 1)), n);
                count = count + n;
            end
        end
    endtask

    initial
    begin
        logic [CntW-1:0] deb;
        logic [CntW-1:0] long_t;
        logic [CntW-1:0] min_t;
        logic [CntW-1:0] blink;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Fastest debounce, half period zero: measure, unconfigured, glitch, long hold.
        set_config(16'd0, 16'd4, 16'd1, 16'd0);
        push_ticks(1'b1, 1'b1, 2);
        push_ticks(1'b0, 1'b1, 3);
        push_ticks(1'b1, 1'b1, 3);
        push_ticks(1'b0, 1'b0, 3);
        push_ticks(1'b1, 1'b0, 3);
        push_ticks(1'b0, 1'b1, 1);
        push_ticks(1'b1, 1'b0, 2);
        push_ticks(1'b0, 1'b1, 8);
        push_ticks(1'b1, 1'b1, 3);
        wait_drained();

        // Zero long time fires on the press tick itself.
        set_config(16'd0, 16'd0, 16'd0, 16'd1);
        push_ticks(1'b0, 1'b0, 3);
        push_ticks(1'b1, 1'b1, 3);
        wait_drained();

        // The longest debounce never accepts a level.
        set_config(16'hFFFF, 16'd1, 16'd0, 16'd1);
        push_ticks(1'b0, 1'b1, 4);
        push_ticks(1'b1, 1'b0, 4);
        wait_drained();

        // Long, minimum and blink registers at their top: a hold below the minimum reports nothing.
        set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_ticks(1'b0, 1'b1, 40);
        push_ticks(1'b1, 1'b1, 4);
        wait_drained();

        // Random settings, each followed by well-formed presses and some noise.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       deb = 16'd0;
                3:       deb = 16'($urandom_range(5, 20));
                default: deb = 16'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 3))
                0:       long_t = 16'd1;
                3:       long_t = 16'($urandom_range(61, 150));
                default: long_t = 16'($urandom_range(2, 60));
            endcase
            case ($urandom_range(0, 3))
                0:       min_t = 16'd0;
                3:       min_t = 16'hFFFF;
                default: min_t = 16'($urandom_range(0, 20));
            endcase
            case ($urandom_range(0, 3))
                0:       blink = 16'd1;
                3:       blink = 16'($urandom_range(9, 40));
                default: blink = 16'($urandom_range(0, 8));
            endcase
            set_config(deb, long_t, min_t, blink);
            random_presses(PHASE_TICKS);
            wait_drained();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
